>>> sv/slao_pkg.sv
// Shared types, constants and the divider step for the slice axis length core.
`timescale 1ns / 1ps

package slao_pkg;

  // Signed width that holds any resolved index or range without overflow.
  localparam int EXT_W       = 34;
  localparam int SIZE_W      = 31;
  localparam int DIVD_W      = 31;
  localparam int DIVS_W      = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_IN_SRC = 3'd1,
    ST_START_BIG  = 3'd2,
    ST_END_BIG    = 3'd3,
    ST_ZERO_STEP  = 3'd4,
    ST_EMPTY      = 3'd5
  } status_t;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic              div_en;
    logic              bin;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] start_pos;
    logic [SIZE_W-1:0] end_pos;
    status_t           status;
  } job_t;

  typedef struct packed {
    logic vld;
    job_t job;
  } job_req_t;

  // Partial remainder plus a shared word that shifts dividend bits out and
  // quotient bits in.
  typedef struct packed {
    logic [DIVS_W-1:0] rem;
    logic [DIVD_W-1:0] qd;
    job_t              job;
  } div_stage_t;

  function automatic div_stage_t div_step(input div_stage_t s);
    logic [DIVS_W:0] trial;
    logic [DIVS_W:0] dvs;
    logic            ge;
    div_stage_t      n;
    trial = {s.rem, s.qd[DIVD_W-1]};
    dvs   = {1'b0, s.job.divisor};
    ge    = (trial >= dvs);
    n     = s;
    n.rem = ge ? DIVS_W'(trial - dvs) : trial[DIVS_W-1:0];
    n.qd  = {s.qd[DIVD_W-2:0], ge};
    return n;
  endfunction

endpackage

>>> sv/slao_front.sv
// Front end: takes a request, resolves and checks the indices, and registers the job.
`timescale 1ns / 1ps

module slao_front #(
  parameter int INDEX_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_pass_through,
  input  logic                 in_in_source,
  input  logic [31:0]          in_start_index,
  input  logic [31:0]          in_end_index,
  input  logic [31:0]          in_step_value,
  input  logic                 in_bin_mode,
  input  logic [30:0]          in_axis_size,
  input  logic                 q_full,
  output slao_pkg::job_req_t   push_req
);

  localparam int EXT_W  = slao_pkg::EXT_W;
  localparam int SIZE_W = slao_pkg::SIZE_W;

  logic signed [INDEX_BITS-1:0] st_n, en_n, sp_n;
  logic signed [EXT_W-1:0]      st_x, en_x, sp_x, sz_x;
  logic signed [EXT_W-1:0]      st_res, en_res, st_c, en_c, mag_x, range_x;
  logic                         start_bad, end_bad, step_zero, range_empty;
  logic                         accept, push;
  slao_pkg::job_t               job;
  logic                         front_vld_r, front_vld_nxt;
  slao_pkg::job_t               front_job_r;

  assign st_n = in_start_index[INDEX_BITS-1:0];
  assign en_n = in_end_index[INDEX_BITS-1:0];
  assign sp_n = in_step_value[INDEX_BITS-1:0];
  assign st_x = EXT_W'(st_n);
  assign en_x = EXT_W'(en_n);
  assign sp_x = EXT_W'(sp_n);
  assign sz_x = $signed({{(EXT_W-SIZE_W){1'b0}}, in_axis_size});

  always_comb begin
    st_res      = st_x[EXT_W-1] ? st_x + sz_x : st_x;
    en_res      = en_x[EXT_W-1] ? en_x + sz_x : en_x;
    st_c        = st_res[EXT_W-1] ? '0 : st_res;
    en_c        = en_res[EXT_W-1] ? '0 : en_res;
    start_bad   = (st_c >= sz_x);
    end_bad     = (en_res >= sz_x);
    mag_x       = sp_x[EXT_W-1] ? -sp_x : sp_x;
    step_zero   = (sp_x == '0);
    // A reversed step measures the range from end up to start.
    range_x     = (!sp_x[EXT_W-1] && !step_zero) ? en_c - st_c + EXT_W'(1)
                                                 : st_c - en_c + EXT_W'(1);
    range_empty = range_x[EXT_W-1] || (range_x == '0);

    job           = '0;
    job.bin       = in_bin_mode;
    job.dividend  = range_x[slao_pkg::DIVD_W-1:0];
    job.divisor   = mag_x[slao_pkg::DIVS_W-1:0];
    job.start_pos = st_c[SIZE_W-1:0];
    job.end_pos   = en_c[SIZE_W-1:0];
    job.status    = slao_pkg::ST_OK;
    priority if (in_pass_through) begin
      job.size      = in_axis_size;
      job.start_pos = '0;
      job.end_pos   = '0;
    end else if (!in_in_source) begin
      job.start_pos = '0;
      job.end_pos   = '0;
      job.status    = slao_pkg::ST_NOT_IN_SRC;
    end else if (start_bad) begin
      job.status = slao_pkg::ST_START_BIG;
    end else if (end_bad) begin
      job.status = slao_pkg::ST_END_BIG;
    end else if (step_zero) begin
      job.status = slao_pkg::ST_ZERO_STEP;
    end else if (range_empty) begin
      job.status = slao_pkg::ST_EMPTY;
    end else begin
      job.div_en = 1'b1;
    end
  end

  assign busy          = front_vld_r & q_full;
  assign accept        = start & ~busy;
  assign push          = front_vld_r & ~q_full;
  assign front_vld_nxt = accept | (front_vld_r & ~push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_vld_r <= 1'b0;
    end else begin
      front_vld_r <= front_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_job_r <= job;
    end
  end

  assign push_req.vld = push;
  assign push_req.job = front_job_r;

endmodule

>>> sv/slao_queue.sv
// Short job queue between the front end and the divider.
`timescale 1ns / 1ps

module slao_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  slao_pkg::job_req_t push_req,
  output logic               full,
  output slao_pkg::job_req_t pop_req
);

  localparam int DEPTH = slao_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  slao_pkg::job_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign full = (count_r == CNT_W'(DEPTH));
  assign push = push_req.vld & ~full;
  // The divider never stalls, so the head leaves as soon as it is there.
  assign pop  = (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_req.job;
    end
  end

  assign pop_req.vld = pop;
  assign pop_req.job = mem_r[rd_ptr_r];

endmodule

>>> sv/slao_divider.sv
// Back end: pipelined restoring divider with rounding and the output register.
`timescale 1ns / 1ps

module slao_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  slao_pkg::job_req_t job_req,
  output logic               out_valid,
  output logic [30:0]        out_length,
  output logic [30:0]        out_resolved_start,
  output logic [30:0]        out_resolved_end,
  output logic [2:0]         out_status
);

  localparam int QBITS  = slao_pkg::DIVD_W;
  localparam int SIZE_W = slao_pkg::SIZE_W;

  logic [QBITS:0]       vld_r;
  slao_pkg::div_stage_t stg_r   [QBITS+1];
  slao_pkg::div_stage_t stg_nxt [QBITS+1];
  slao_pkg::div_stage_t last;
  logic [SIZE_W-1:0]    quot, size_nxt;

  always_comb begin
    stg_nxt[0].rem = '0;
    stg_nxt[0].qd  = job_req.job.dividend;
    stg_nxt[0].job = job_req.job;
    for (int k = 0; k < QBITS; k++) begin
      stg_nxt[k+1] = slao_pkg::div_step(stg_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[QBITS-1:0], job_req.vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= QBITS; k++) begin
      stg_r[k] <= stg_nxt[k];
    end
  end

  // Binning keeps the floor, striding rounds up, and a divided length is never zero.
  assign last = stg_r[QBITS];
  always_comb begin
    quot = (last.job.bin || last.rem == '0) ? last.qd : last.qd + SIZE_W'(1);
    if (quot == '0) begin
      quot = SIZE_W'(1);
    end
    size_nxt = last.job.div_en ? quot : last.job.size;
  end

  logic                 out_valid_r;
  logic [SIZE_W-1:0]    out_length_r, out_start_r, out_end_r;
  slao_pkg::status_t    out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    out_length_r <= size_nxt;
    out_start_r  <= last.job.start_pos;
    out_end_r    <= last.job.end_pos;
    out_status_r <= last.job.status;
  end

  assign out_valid          = out_valid_r;
  assign out_length         = out_length_r;
  assign out_resolved_start = out_start_r;
  assign out_resolved_end   = out_end_r;
  assign out_status         = out_status_r;

endmodule

>>> sv/slice_axis_output_length_core.sv
// Top level of the slice axis output length core.
// Path: the accepting edge loads the front register; then come one queue slot, the divider
// input register, 31 divider stages and the output register, which drives the result strobe.
// Throughput: one request per clock; the divider pipeline never stalls.
// Reset: synchronous, active low; it empties the queue and all pipeline valid bits.
// The receiver cannot stall, so busy stays low in operation.
`timescale 1ns / 1ps

module slice_axis_output_length_core #(
  parameter int INDEX_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_pass_through,
  input  logic        in_in_source,
  input  logic [31:0] in_start_index,
  input  logic [31:0] in_end_index,
  input  logic [31:0] in_step_value,
  input  logic        in_bin_mode,
  input  logic [30:0] in_axis_size,
  output logic        out_valid,
  output logic [30:0] out_length,
  output logic [30:0] out_resolved_start,
  output logic [30:0] out_resolved_end,
  output logic [2:0]  out_status
);

  // The front end resolves negative indices against the axis size, clamps
  // them at zero, runs the error checks in priority order and forms the
  // range and the step magnitude. Each request leaves it as one job.
  slao_pkg::job_req_t push_req;
  slao_pkg::job_req_t pop_req;
  logic               q_full;

  slao_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_pass_through (in_pass_through),
    .in_in_source    (in_in_source),
    .in_start_index  (in_start_index),
    .in_end_index    (in_end_index),
    .in_step_value   (in_step_value),
    .in_bin_mode     (in_bin_mode),
    .in_axis_size    (in_axis_size),
    .q_full          (q_full),
    .push_req        (push_req)
  );

  // The queue decouples the front end from the divider. Since the divider
  // drains a job every cycle, the queue holds at most one job in practice.
  slao_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_req (push_req),
    .full     (q_full),
    .pop_req  (pop_req)
  );

  // The back end computes one quotient bit per stage. Jobs that need no
  // division ride through the same stages so that order is kept.
  slao_divider u_divider (
    .clk                (clk),
    .rst_n              (rst_n),
    .job_req            (pop_req),
    .out_valid          (out_valid),
    .out_length         (out_length),
    .out_resolved_start (out_resolved_start),
    .out_resolved_end   (out_resolved_end),
    .out_status         (out_status)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the slice axis output length core.
`timescale 1ns / 1ps

module tb;

  // The drain wait covers the core's answer to a request it has taken, with a margin on top.
  localparam int DRAIN_CYCLES = 40;
  // Bound on the run length, set well above what the slowest correct run needs.
  localparam int CYCLE_LIMIT  = 60000;
  localparam int RANDOM_AXES  = 2000;
  localparam int PRINT_LIMIT  = 50;

  // One expected answer from the core, laid out like its result ports.
  typedef struct packed {
    logic [30:0]       size;
    logic [30:0]       start_pos;
    logic [30:0]       end_pos;
    slao_pkg::status_t status;
  } axis_result_t;

  logic        clk;
  logic        rst_n              = 1'b0;
  logic        start              = 1'b0;
  logic        busy;
  logic        in_pass_through    = 1'b0;
  logic        in_in_source       = 1'b0;
  logic [31:0] in_start_index     = '0;
  logic [31:0] in_end_index       = '0;
  logic [31:0] in_step_value      = '0;
  logic        in_bin_mode        = 1'b0;
  logic [30:0] in_axis_size       = '0;
  logic        out_valid;
  logic [30:0] out_length;
  logic [30:0] out_resolved_start;
  logic [30:0] out_resolved_end;
  logic [2:0]  out_status;

  // Answers still owed by the core, oldest first.
  axis_result_t pending_lengths[$];
  int           error_count = 0;
  int           cycle_count = 0;
  // While set, the sender issues one request per cycle without any gaps, as long as busy stays low.
  bit           steady_issue = 1'b0;

  slice_axis_output_length_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_pass_through    (in_pass_through),
    .in_in_source       (in_in_source),
    .in_start_index     (in_start_index),
    .in_end_index       (in_end_index),
    .in_step_value      (in_step_value),
    .in_bin_mode        (in_bin_mode),
    .in_axis_size       (in_axis_size),
    .out_valid          (out_valid),
    .out_length         (out_length),
    .out_resolved_start (out_resolved_start),
    .out_resolved_end   (out_resolved_end),
    .out_status         (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. A hang anywhere in the run ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Works out the answer for one axis descriptor. All arithmetic is done in 64 bits,
  // so resolving a negative index against the size can never overflow.
  function automatic axis_result_t predict_axis_length(
    input logic        pass,
    input logic        src,
    input logic [31:0] start_raw,
    input logic [31:0] end_raw,
    input logic [31:0] step_raw,
    input logic        bin,
    input logic [30:0] size_raw
  );
    longint       st;
    longint       en;
    longint       sp;
    longint       sz;
    longint       mag;
    longint       span;
    longint       q;
    axis_result_t r;
    r  = '0;
    st = longint'(signed'(start_raw));
    en = longint'(signed'(end_raw));
    sp = longint'(signed'(step_raw));
    sz = longint'(size_raw);
    r.status = slao_pkg::ST_OK;
    // A pass-through axis wins over every check, including a missing axis.
    if (pass) begin
      r.size = size_raw;
      return r;
    end
    if (!src) begin
      r.status = slao_pkg::ST_NOT_IN_SRC;
      return r;
    end
    if (st < 0) st += sz;
    if (en < 0) en += sz;
    if (st < 0) st = 0;
    // The start check comes first. The end is compared before it is clamped.
    if (st >= sz) r.status = slao_pkg::ST_START_BIG;
    else if (en >= sz) r.status = slao_pkg::ST_END_BIG;
    if (en < 0) en = 0;
    if (r.status == slao_pkg::ST_OK) begin
      // The most negative step gives a magnitude of 2^31, and 64 bits hold it exactly.
      mag = (sp < 0) ? -sp : sp;
      if (mag == 0) begin
        r.status = slao_pkg::ST_ZERO_STEP;
      end else begin
        // A reversed step measures the range from the end up to the start.
        span = (sp > 0) ? (en - st + 1) : (st - en + 1);
        if (span <= 0) begin
          r.status = slao_pkg::ST_EMPTY;
        end else begin
          q = bin ? (span / mag) : ((span + mag - 1) / mag);
          if (q == 0) q = 1;
          r.size = q[30:0];
        end
      end
    end
    r.start_pos = st[30:0];
    r.end_pos   = en[30:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < PRINT_LIMIT)
      $display("tb: mismatch on %s at cycle %0d: got %h, want %h", what, cycle_count,
               got, want);
    error_count++;
  endtask

  // Sends one request. It may idle first, and it returns on the edge that accepts the request.
  // When it idles, start is lowered once. A request that follows at once keeps start high, so
  // start is never lowered and raised again within one time step.
  task automatic send_axis(input logic pass, input logic src, input logic [31:0] st,
                           input logic [31:0] en, input logic [31:0] sp,
                           input logic bin, input logic [30:0] sz);
    int gap;
    gap = 0;
    if (!steady_issue && $urandom_range(0, 99) < 35) gap = $urandom_range(1, 2);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_pass_through <= pass;
    in_in_source    <= src;
    in_start_index  <= st;
    in_end_index    <= en;
    in_step_value   <= sp;
    in_bin_mode     <= bin;
    in_axis_size    <= sz;
    // Values read here are the ones from before the edge, which are the ones the core saw.
    do @(posedge clk); while (busy);
    pending_lengths.push_back(predict_axis_length(pass, src, st, en, sp, bin, sz));
  endtask

  // Holds the sender off until every answer owed so far has come back.
  task automatic wait_until_drained();
    start <= 1'b0;
    while (pending_lengths.size() != 0) @(posedge clk);
  endtask

  // Picks a start or end index for a random axis. Most fall inside the axis, in either form:
  // counted from the front, or negative and counted back from the end. A few fall past either side.
  function automatic logic [31:0] pick_index(input logic [30:0] sz);
    longint p;
    int     r;
    r = $urandom_range(0, 19);
    if (sz == 0)      p = longint'($urandom_range(0, 4)) - 2;
    else if (r == 0)  p = longint'(sz) + $urandom_range(0, 2);
    else if (r == 1)  p = -longint'(sz) - 1 - $urandom_range(0, 2);
    else begin
      p = longint'($urandom_range(0, sz - 1));
      if ($urandom_range(0, 1)) p -= longint'(sz);
    end
    return p[31:0];
  endfunction

  // A pass-through axis copies the size even when the axis is absent from the source.
  task automatic test_pass_through();
    send_axis(1'b1, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1, 31'h7FFF_FFFF);
    send_axis(1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 1'b0, 31'h0);
  endtask

  // An axis missing from the source reports zeros everywhere else.
  task automatic test_not_in_source();
    send_axis(1'b0, 1'b0, 32'h0, 32'hFFFF_FFFF, 32'h1, 1'b0, 31'd10);
    send_axis(1'b0, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1, 31'h7FFF_FFFF);
  endtask

  // Errors in the order the core checks them. A later error must not hide an earlier one.
  task automatic test_error_order();
    // On a zero-size axis every start fails the start check.
    send_axis(1'b0, 1'b1, 32'h0, 32'h0, 32'h1, 1'b0, 31'h0);
    // The start reaches the size. In the first, the end is past it and the step is zero.
    send_axis(1'b0, 1'b1, 32'd10, 32'd20, 32'h0, 1'b0, 31'd10);
    send_axis(1'b0, 1'b1, 32'h7FFF_FFFF, 32'h0, 32'h1, 1'b0, 31'h7FFF_FFFF);
    // The end reaches the size. In the first, the step is zero as well.
    send_axis(1'b0, 1'b1, 32'd2, 32'd10, 32'h0, 1'b1, 31'd10);
    send_axis(1'b0, 1'b1, 32'h0, 32'h7FFF_FFFF, 32'h1, 1'b0, 31'h7FFF_FFFF);
    // A zero step on an otherwise valid range.
    send_axis(1'b0, 1'b1, 32'd1, 32'd5, 32'h0, 1'b0, 31'd10);
    // An empty range, first going forward and then going backward.
    send_axis(1'b0, 1'b1, 32'd5, 32'd2, 32'd1, 1'b0, 31'd10);
    send_axis(1'b0, 1'b1, 32'd2, 32'd5, 32'hFFFF_FFFF, 1'b1, 31'd10);
  endtask

  // Index resolution and the two kinds of division.
  task automatic test_range_math();
    // Negative indices count back from the end: elements 7..9.
    send_axis(1'b0, 1'b1, -32'sd3, -32'sd1, 32'd1, 1'b0, 31'd10);
    // A most negative start and end clamp to zero and leave a range of one.
    send_axis(1'b0, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'd1, 1'b0, 31'd10);
    // Reversed strides over 9..0, by two rounded up and then by three floored.
    send_axis(1'b0, 1'b1, 32'd9, 32'd0, -32'sd2, 1'b0, 31'd10);
    send_axis(1'b0, 1'b1, 32'd9, 32'd0, -32'sd3, 1'b1, 31'd10);
    // A range of ten in steps of three: the floor gives three and the ceiling gives four.
    send_axis(1'b0, 1'b1, 32'd0, 32'd9, 32'd3, 1'b1, 31'd10);
    send_axis(1'b0, 1'b1, 32'd0, 32'd9, 32'd3, 1'b0, 31'd10);
    // A bin wider than the range still yields one element.
    send_axis(1'b0, 1'b1, 32'd2, 32'd4, 32'd100, 1'b1, 31'd10);
  endtask

  // Full-size axes, with the largest steps of either sign.
  task automatic test_extremes();
    send_axis(1'b0, 1'b1, 32'h0, 32'hFFFF_FFFF, 32'd1, 1'b0, 31'h7FFF_FFFF);
    send_axis(1'b0, 1'b1, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 31'h7FFF_FFFF);
    send_axis(1'b0, 1'b1, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 1'b0, 31'h7FFF_FFFF);
    send_axis(1'b0, 1'b1, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 1'b1, 31'h7FFF_FFFF);
    send_axis(1'b0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFE, 32'h8000_0001, 1'b0, 31'h7FFF_FFFF);
  endtask

  // Random axes. Most are well formed, with a random size, indices and step. About one in
  // seven is pure noise on every field. The middle part runs back to back with no idling,
  // and halfway through the sender waits for the core to drain.
  task automatic test_random_axes(input int count);
    int          i;
    int          kind;
    logic        pass;
    logic        src;
    logic        bin;
    logic [30:0] sz;
    logic [31:0] st;
    logic [31:0] en;
    logic [31:0] sp;
    for (i = 0; i < count; i++) begin
      steady_issue = (i >= count * 2 / 5) && (i < count * 3 / 5);
      if (i == count / 2) wait_until_drained();
      pass = ($urandom_range(0, 99) < 4);
      src  = ($urandom_range(0, 99) >= 4);
      bin  = 1'($urandom_range(0, 1));
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        st = $urandom;
        en = $urandom;
        sp = $urandom;
        sz = 31'($urandom);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: sz = 31'($urandom_range(0, 64));
          6, 7, 8:          sz = 31'($urandom_range(0, 65535));
          default:          sz = 31'($urandom);
        endcase
        st = pick_index(sz);
        en = pick_index(sz);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: sp = $urandom_range(1, 8);
          7, 8:                sp = $urandom_range(1, (sz == 0) ? 1 : sz);
          default:             sp = $urandom_range(0, 1) ? 32'h0 : $urandom;
        endcase
        if ($urandom_range(0, 1)) sp = -sp;
      end
      send_axis(pass, src, st, en, sp, bin, sz);
    end
    steady_issue = 1'b0;
  endtask

  // Compares every result with the oldest answer still owed. Every result must be matched.
  always @(posedge clk) begin
    axis_result_t want;
    if (rst_n && out_valid) begin
      if (pending_lengths.size() == 0) begin
        report_mismatch("unrequested result", {1'b0, out_length}, 32'h0);
      end else begin
        want = pending_lengths.pop_front();
        if (out_length !== want.size)
          report_mismatch("out_length", {1'b0, out_length}, {1'b0, want.size});
        if (out_resolved_start !== want.start_pos)
          report_mismatch("out_resolved_start", {1'b0, out_resolved_start},
                          {1'b0, want.start_pos});
        if (out_resolved_end !== want.end_pos)
          report_mismatch("out_resolved_end", {1'b0, out_resolved_end},
                          {1'b0, want.end_pos});
        if (out_status !== want.status)
          report_mismatch("out_status", {29'h0, out_status}, {29'h0, want.status});
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pass_through();
    test_not_in_source();
    test_error_order();
    // Let the directed requests drain before the math tests begin.
    wait_until_drained();
    test_range_math();
    test_extremes();
    test_random_axes(RANDOM_AXES);

    // Everything has been sent. Wait for the last answers, then check for stray strobes.
    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_lengths.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> slice_axis_output_length_core.f
sv/slao_pkg.sv
sv/slao_front.sv
sv/slao_queue.sv
sv/slao_divider.sv
sv/slice_axis_output_length_core.sv
tb/tb.sv
